// File: sv/dfir_pkg.sv
// Package with shared constants, the coefficient table and the decision type.
`default_nettype none
package dfir_pkg;
	localparam int COEF_COUNT = 101;
	localparam int COEF_BITS = 20;
	localparam int PHASE_BITS = 6;
	localparam int ACC_BITS = 64;
	localparam logic [PHASE_BITS-1:0] DECIM_RESET = 6'd10;
	localparam logic [1:0] REG_DECIM = 2'd0;

	// Front-to-back decision for one accepted sample.
	typedef struct packed {
		logic fire;
	} dfir_cmd_t;

	// Coefficient k of the symmetric Q23 table; taps past the table read as zero.
	function automatic logic signed [COEF_BITS-1:0] coef_at(input logic [7:0] k);
		logic signed [COEF_BITS-1:0] c;
		logic [7:0] m;
		m = (k > 8'd50) ? 8'd100 - k : k;
		unique case (m)
			8'd0: c = 448; 8'd1: c = 441; 8'd2: c = 622; 8'd3: c = 816;
			8'd4: c = 1003; 8'd5: c = 1158; 8'd6: c = 1247; 8'd7: c = 1228;
			8'd8: c = 1053; 8'd9: c = 672; 8'd10: c = 30; 8'd11: c = -926;
			8'd12: c = -2244; 8'd13: c = -3962; 8'd14: c = -6102; 8'd15: c = -8669;
			8'd16: c = -11642; 8'd17: c = -14971; 8'd18: c = -18572;
			8'd19: c = -22326; 8'd20: c = -26078; 8'd21: c = -29633;
			8'd22: c = -32762; 8'd23: c = -35206; 8'd24: c = -36679;
			8'd25: c = -36880; 8'd26: c = -35501; 8'd27: c = -32238;
			8'd28: c = -26804; 8'd29: c = -18944; 8'd30: c = -8447; 8'd31: c = 4841;
			8'd32: c = 21003; 8'd33: c = 40044; 8'd34: c = 61882; 8'd35: c = 86338;
			8'd36: c = 113144; 8'd37: c = 141936; 8'd38: c = 172264;
			8'd39: c = 203601; 8'd40: c = 235352; 8'd41: c = 266877;
			8'd42: c = 297502; 8'd43: c = 326546; 8'd44: c = 353339;
			8'd45: c = 377242; 8'd46: c = 397673; 8'd47: c = 414127;
			8'd48: c = 426189; 8'd49: c = 433552; 8'd50: c = 436028;
			default: c = '0;
		endcase
		if (k >= 8'(COEF_COUNT)) c = '0;
		return c;
	endfunction
endpackage
`default_nettype wire

// File: sv/dfir_if.sv
// Valid/ready channel interface carrying one signed sample word.
`default_nettype none
interface dfir_if #(parameter int W = 24);
	logic valid;
	logic ready;
	logic signed [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/dfir_front.sv
// Front part: accepts samples, writes the history and decides when to filter.
`default_nettype none
module dfir_front #(
	parameter int TAPS = 101,
	parameter int SAMPLE_BITS = 24,
	parameter int PW = 7
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0] in_data,
	input  wire logic [dfir_pkg::PHASE_BITS-1:0] decim,
	input  wire logic q_full,
	output logic q_push,
	output dfir_pkg::dfir_cmd_t q_cmd,
	output logic wr_en,
	output logic [PW-1:0] wr_addr,
	output logic signed [SAMPLE_BITS-1:0] wr_data,
	output logic [PW-1:0] newest,
	input  wire logic clr_busy
);
	import dfir_pkg::*;
	logic [PW-1:0] wpos_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic [PHASE_BITS-1:0] phase_nx;
	logic acc;

	assign in_ready = !q_full && !clr_busy;
	assign acc = in_valid && in_ready;
	assign phase_nx = phase_q + 1'b1;
	assign wr_en = acc;
	assign wr_addr = wpos_q;
	assign wr_data = in_data;
	assign q_push = acc;
	assign q_cmd.fire = (phase_nx == decim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q <= '0;
			phase_q <= '0;
			newest <= '0;
		end else if (acc) begin
			newest <= wpos_q;
			wpos_q <= (wpos_q == PW'(TAPS-1)) ? '0 : wpos_q + 1'b1;
			phase_q <= (phase_nx == decim) ? '0 : phase_nx;
		end
	end
endmodule
`default_nettype wire

// File: sv/dfir_back.sv
// Back part: history memory, one shared MAC sweep, rounding and saturation.
`default_nettype none
module dfir_back #(
	parameter int TAPS = 101,
	parameter int SAMPLE_BITS = 24,
	parameter int FRAC_BITS = 23,
	parameter int PW = 7
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire logic [PW-1:0] wr_addr,
	input  wire logic signed [SAMPLE_BITS-1:0] wr_data,
	input  wire logic [PW-1:0] newest,
	input  wire logic q_push,
	input  wire dfir_pkg::dfir_cmd_t q_cmd,
	output logic q_full,
	output logic clr_busy,
	output logic out_valid,
	input  wire logic out_ready,
	output logic signed [SAMPLE_BITS-1:0] out_data
);
	import dfir_pkg::*;
	localparam logic [2:0] ST_IDLE = 3'd0, ST_RUN = 3'd1, ST_DRAIN = 3'd2,
		ST_ROUND = 3'd3, ST_CLEAR = 3'd4;
	localparam int PB = COEF_BITS + SAMPLE_BITS;

	logic signed [SAMPLE_BITS-1:0] mem [TAPS];
	logic signed [SAMPLE_BITS-1:0] rd_q;
	logic [2:0] st_q;
	logic [PW-1:0] rpos_q;
	logic [7:0] k_q;
	logic [7:0] k_s1;
	logic rd_v_s1;
	logic prod_v_s2;
	logic signed [PB-1:0] prod_s2;
	logic signed [ACC_BITS-1:0] acc_q;
	logic cmd_v_q;
	dfir_cmd_t cmd_q;
	logic [1:0] cnt_q;
	logic [ACC_BITS-1:0] mag;
	logic [ACC_BITS-1:0] qv;
	logic signed [ACC_BITS-1:0] res;
	logic signed [ACC_BITS-1:0] hi;
	logic signed [ACC_BITS-1:0] lo;
	logic [PW-1:0] mem_wa;
	logic mem_we;
	logic start;
	logic pop;

	// One-entry decision queue. A non-firing word pops once the back is idle and
	// no result is pending; a firing word stays queued until its sweep ends, which
	// holds off the front so that no new sample lands in the history mid-sweep.
	assign q_full = cmd_v_q;
	assign start = cmd_v_q && (st_q == ST_IDLE) && !out_valid;
	assign pop = (start && !cmd_q.fire) || (st_q == ST_ROUND);
	assign clr_busy = (st_q == ST_CLEAR);
	assign mem_we = clr_busy || wr_en;
	assign mem_wa = clr_busy ? rpos_q : wr_addr;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= clr_busy ? '0 : wr_data;
		rd_q <= mem[rpos_q];
	end

	always_ff @(posedge clk) begin
		prod_s2 <= PB'(rd_q) * PB'(coef_at(k_s1));
	end

	assign mag = acc_q[ACC_BITS-1] ? ACC_BITS'(0) - acc_q : acc_q;
	assign qv = (mag + (ACC_BITS'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
	assign res = acc_q[ACC_BITS-1] ? -$signed(qv) : $signed(qv);
	assign hi = (ACC_BITS'(1) <<< (SAMPLE_BITS-1)) - 1;
	assign lo = -hi - 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			rpos_q <= '0;
			k_q <= '0;
			k_s1 <= '0;
			rd_v_s1 <= 1'b0;
			prod_v_s2 <= 1'b0;
			acc_q <= '0;
			cmd_v_q <= 1'b0;
			cmd_q <= '0;
			cnt_q <= '0;
			out_valid <= 1'b0;
			out_data <= '0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (q_push) begin
				cmd_v_q <= 1'b1;
				cmd_q <= q_cmd;
			end else if (pop) begin
				cmd_v_q <= 1'b0;
			end
			rd_v_s1 <= 1'b0;
			prod_v_s2 <= rd_v_s1;
			if (prod_v_s2) acc_q <= acc_q + ACC_BITS'(prod_s2);
			unique case (st_q)
				ST_CLEAR: begin
					rpos_q <= (rpos_q == PW'(TAPS-1)) ? '0 : rpos_q + 1'b1;
					if (rpos_q == PW'(TAPS-1)) st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start && cmd_q.fire) begin
						st_q <= ST_RUN;
						rpos_q <= newest;
						k_q <= '0;
						acc_q <= '0;
					end
				end
				ST_RUN: begin
					rd_v_s1 <= 1'b1;
					k_s1 <= k_q;
					k_q <= k_q + 1'b1;
					rpos_q <= (rpos_q == '0) ? PW'(TAPS-1) : rpos_q - 1'b1;
					if (k_q == 8'(TAPS-1)) begin
						st_q <= ST_DRAIN;
						cnt_q <= '0;
					end
				end
				ST_DRAIN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 2'd2) st_q <= ST_ROUND;
				end
				ST_ROUND: begin
					out_valid <= 1'b1;
					out_data <= (res > hi) ? hi[SAMPLE_BITS-1:0] :
						(res < lo) ? lo[SAMPLE_BITS-1:0] : res[SAMPLE_BITS-1:0];
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: sv/decimating_fir_filter_top.sv
// Top level of the decimating FIR filter with its configuration port.
`default_nettype none
// Decimating 101-tap FIR filter. Each accepted word is one signed sample that
// goes into a circular history; every decimation_factor-th sample (register 0
// at byte address 0, reset value 10) starts a sweep of one shared
// multiply-accumulate unit over the history, newest sample first, against the
// symmetric Q23 coefficient table. The sum is scaled by 2^-23, rounded half away
// from zero and saturated to the sample width. A sample that causes no result
// is accepted and its decision is then popped from the queue; one that fires
// stays queued while the single MAC sweeps every tap through the history
// memory read port, and no new sample is accepted until its sweep is done. A
// pending result that has not been taken holds the next decision in the queue.
// After reset the history is cleared, during which no sample is accepted.
module decimating_fir_filter_top #(
	parameter int TAPS = 101,
	parameter int FRAC_BITS = 23,
	parameter int SAMPLE_BITS = 24
) (
	input  wire logic clk,
	input  wire logic arst_n,
	dfir_if.sink samples,
	dfir_if.source results,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [1:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import dfir_pkg::*;
	localparam int PW = $clog2(TAPS);

	logic [PHASE_BITS-1:0] decim_q;
	logic q_full, q_push, wr_en, clr_busy;
	dfir_cmd_t q_cmd;
	logic [PW-1:0] wr_addr, newest;
	logic signed [SAMPLE_BITS-1:0] wr_data;

	// The only register is the decimation factor; other addresses read zero.
	assign pready = 1'b1;
	assign prdata = (paddr == REG_DECIM) ? 32'(decim_q) : '0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decim_q <= DECIM_RESET;
		end else if (psel && penable && pwrite && paddr == REG_DECIM) begin
			decim_q <= pwdata[PHASE_BITS-1:0];
		end
	end

	// The front classifies each sample and the back runs the filter sweep.
	dfir_front #(.TAPS(TAPS), .SAMPLE_BITS(SAMPLE_BITS), .PW(PW)) u_front (
		.clk, .arst_n,
		.in_valid(samples.valid), .in_ready(samples.ready), .in_data(samples.data),
		.decim(decim_q), .q_full, .q_push, .q_cmd,
		.wr_en, .wr_addr, .wr_data, .newest, .clr_busy
	);

	dfir_back #(.TAPS(TAPS), .SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS), .PW(PW))
		u_back (
		.clk, .arst_n, .wr_en, .wr_addr, .wr_data, .newest,
		.q_push, .q_cmd, .q_full, .clr_busy,
		.out_valid(results.valid), .out_ready(results.ready), .out_data(results.data)
	);
endmodule
`default_nettype wire
